// File: design/apl_pkg.sv
// Shared types and constants for the audio peak level meter.
// Used by the channel interfaces, the controller, the datapath and the top level.
package apl_pkg;

	localparam int unsigned WordW    = 32;
	localparam int unsigned LevelW   = 7;
	localparam int unsigned MinW     = 8;
	localparam int unsigned GainW    = 8;
	localparam int unsigned MultW    = 12;
	localparam int unsigned QuoW     = 7;
	localparam int unsigned NumW     = WordW + QuoW;
	localparam int unsigned ProdW    = QuoW + MultW;
	localparam int unsigned CntW     = 3;
	localparam int unsigned CfgIdxW  = 2;
	localparam int unsigned CfgDataW = 12;

	// Configuration register indexes.
	localparam logic [CfgIdxW-1:0] REG_SAMPLE_FORMAT = 2'd0;
	localparam logic [CfgIdxW-1:0] REG_BIG_ENDIAN    = 2'd1;
	localparam logic [CfgIdxW-1:0] REG_LEVEL_GAIN    = 2'd2;
	localparam logic [CfgIdxW-1:0] REG_LEVEL_MULT    = 2'd3;

	// Sample format codes.
	localparam logic [2:0] FMT_U8  = 3'd0;
	localparam logic [2:0] FMT_S8  = 3'd1;
	localparam logic [2:0] FMT_U16 = 3'd2;
	localparam logic [2:0] FMT_S16 = 3'd3;
	localparam logic [2:0] FMT_U32 = 3'd4;
	localparam logic [2:0] FMT_S32 = 3'd5;

	// Input command codes.
	localparam logic CMD_SAMPLE = 1'b0;
	localparam logic CMD_CLEAR  = 1'b1;

	localparam logic [WordW-1:0] FS_U8  = 32'd255;
	localparam logic [WordW-1:0] FS_S8  = 32'd127;
	localparam logic [WordW-1:0] FS_U16 = 32'd65535;
	localparam logic [WordW-1:0] FS_S16 = 32'd32767;
	localparam logic [WordW-1:0] FS_U32 = 32'hffff_ffff;
	localparam logic [WordW-1:0] FS_S32 = 32'h7fff_ffff;

	localparam logic [LevelW-1:0] PERCENT     = 7'd100;
	localparam logic [MultW-1:0]  MULT_UNITY  = 12'd256;
	localparam logic [MinW-1:0]   MIN_NONE    = 8'hff;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_SCALE,
		ST_ADJ
	} apl_state_t;

	typedef struct packed {
		logic            acc_en;
		logic            last_load;
		logic            clear_tel;
		logic            mul_en;
		logic            div_en;
		logic [CntW-1:0] div_idx;
		logic            scale_en;
		logic            commit;
	} apl_ctl_t;

	typedef struct packed {
		logic fs_valid;
		logic out_free;
	} apl_stat_t;

endpackage

// File: design/apl_if.sv
// Valid/ready channel interfaces for the audio peak level meter.
// Depends on apl_pkg for field widths.
interface apl_in_if;
	logic                        valid;
	logic                        ready;
	logic                        cmd;
	logic [apl_pkg::WordW-1:0]   sample_word;
	logic                        last_sample;

	modport source (output valid, output cmd, output sample_word, output last_sample,
		input ready);
	modport sink (input valid, input cmd, input sample_word, input last_sample,
		output ready);
endinterface

interface apl_out_if;
	logic                             valid;
	logic                             ready;
	logic [apl_pkg::LevelW-1:0]       level_raw;
	logic [apl_pkg::LevelW-1:0]       level_adjusted;
	logic signed [apl_pkg::MinW-1:0]  level_min;
	logic [apl_pkg::LevelW-1:0]       level_max;

	modport source (output valid, output level_raw, output level_adjusted,
		output level_min, output level_max, input ready);
	modport sink (input valid, input level_raw, input level_adjusted,
		input level_min, input level_max, output ready);
endinterface

interface apl_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [apl_pkg::CfgIdxW-1:0]    index;
	logic [apl_pkg::CfgDataW-1:0]   data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// File: design/audio_peak_level_meter_top.sv
// Channel     | Dir | Word carried
// in_ch       | in  | cmd, sample_word, last_sample
// out_ch      | out | level_raw, level_adjusted, level_min, level_max
// cfg         | in  | index, data (always ready)
//
// A sample that does not end a buffer, and a clear command, are each taken in the idle state.
// A sample that ends a buffer, when the format has a full scale, holds off the next word
// while it steps through: load the peak, multiply by 100, the bit-serial divide by full
// scale over the seven quotient bits, apply the multiplier, and add gain and commit.
// The commit waits while the result register still holds an untaken result.
// Reset is asynchronous and active low; configuration takes its reset values.
// Top level of the audio peak level meter; depends on apl_pkg, apl_if, apl_ctrl and apl_dp.
module audio_peak_level_meter_top (
	input  logic          clk,
	input  logic          arst_n,
	apl_in_if.sink        in_ch,
	apl_out_if.source     out_ch,
	apl_cfg_if.sink       cfg
);

	apl_pkg::apl_ctl_t   ctl;
	apl_pkg::apl_stat_t  stat;

	assign cfg.ready = 1'b1;

	apl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_cmd   (in_ch.cmd),
		.in_last  (in_ch.last_sample),
		.in_ready (in_ch.ready),
		.stat     (stat),
		.ctl      (ctl)
	);

	apl_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg.valid),
		.cfg_index      (cfg.index),
		.cfg_data       (cfg.data),
		.sample_word    (in_ch.sample_word),
		.ctl            (ctl),
		.stat           (stat),
		.out_ready      (out_ch.ready),
		.out_valid      (out_ch.valid),
		.level_raw      (out_ch.level_raw),
		.level_adjusted (out_ch.level_adjusted),
		.level_min      (out_ch.level_min),
		.level_max      (out_ch.level_max)
	);

endmodule

// File: design/apl_ctrl.sv
// Controller of the audio peak level meter: sequences the level computation.
// Depends on apl_pkg for the state type and the command and status structs.
module apl_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_cmd,
	input  logic                          in_last,
	output logic                          in_ready,
	input  apl_pkg::apl_stat_t            stat,
	output apl_pkg::apl_ctl_t             ctl
);

	apl_pkg::apl_state_t               state_q;
	apl_pkg::apl_state_t               state_nxt;
	logic [apl_pkg::CntW-1:0]          cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= apl_pkg::ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_nxt;
			if (state_q == apl_pkg::ST_MUL) begin
				cnt_q <= apl_pkg::CntW'(apl_pkg::QuoW - 1);
			end else if (state_q == apl_pkg::ST_DIV) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			apl_pkg::ST_IDLE: begin
				if (in_valid && in_cmd == apl_pkg::CMD_SAMPLE && in_last && stat.fs_valid) begin
					state_nxt = apl_pkg::ST_MUL;
				end
			end
			apl_pkg::ST_MUL: state_nxt = apl_pkg::ST_DIV;
			apl_pkg::ST_DIV: begin
				if (cnt_q == '0) begin
					state_nxt = apl_pkg::ST_SCALE;
				end
			end
			apl_pkg::ST_SCALE: state_nxt = apl_pkg::ST_ADJ;
			apl_pkg::ST_ADJ: begin
				if (stat.out_free) begin
					state_nxt = apl_pkg::ST_IDLE;
				end
			end
			default: state_nxt = apl_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		ctl      = '0;
		unique case (state_q)
			apl_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (in_cmd == apl_pkg::CMD_CLEAR) begin
						ctl.clear_tel = 1'b1;
					end else begin
						ctl.acc_en    = 1'b1;
						ctl.last_load = in_last;
					end
				end
			end
			apl_pkg::ST_MUL:   ctl.mul_en = 1'b1;
			apl_pkg::ST_DIV: begin
				ctl.div_en  = 1'b1;
				ctl.div_idx = cnt_q;
			end
			apl_pkg::ST_SCALE: ctl.scale_en = 1'b1;
			apl_pkg::ST_ADJ:   ctl.commit = stat.out_free;
			default: ;
		endcase
	end

endmodule

// File: design/apl_dp.sv
// Datapath of the audio peak level meter: configuration registers, sample
// decode, peak tracking, level division, scaling and the result register.
// Depends on apl_pkg; driven by apl_ctrl through apl_ctl_t.
module apl_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	input  logic [apl_pkg::CfgIdxW-1:0]         cfg_index,
	input  logic [apl_pkg::CfgDataW-1:0]        cfg_data,
	input  logic [apl_pkg::WordW-1:0]           sample_word,
	input  apl_pkg::apl_ctl_t                   ctl,
	output apl_pkg::apl_stat_t                  stat,
	input  logic                                out_ready,
	output logic                                out_valid,
	output logic [apl_pkg::LevelW-1:0]          level_raw,
	output logic [apl_pkg::LevelW-1:0]          level_adjusted,
	output logic signed [apl_pkg::MinW-1:0]     level_min,
	output logic [apl_pkg::LevelW-1:0]          level_max
);

	logic [2:0]                         fmt_q;
	logic                               be_q;
	logic signed [apl_pkg::GainW-1:0]   gain_q;
	logic [apl_pkg::MultW-1:0]          mult_q;

	logic [apl_pkg::WordW-1:0]          peak_acc_q;
	logic [apl_pkg::WordW-1:0]          peak_w_q;
	logic [apl_pkg::NumW-1:0]           num_q;
	logic [apl_pkg::QuoW-1:0]           quo_q;
	logic [apl_pkg::ProdW-1:0]          prod_q;
	logic signed [apl_pkg::MinW-1:0]    min_q;
	logic [apl_pkg::LevelW-1:0]         max_q;
	logic                               out_valid_q;

	logic [7:0]                         b0, b1, b2, b3;
	logic [15:0]                        v16;
	logic [apl_pkg::WordW-1:0]          v32;
	logic [apl_pkg::WordW-1:0]          mag;
	logic [apl_pkg::WordW-1:0]          fs;
	logic [apl_pkg::WordW-1:0]          peak_max;
	logic [apl_pkg::WordW-1:0]          peak_clamp;
	logic [apl_pkg::NumW-1:0]           div_sub;
	logic                               div_ge;
	logic signed [12:0]                 adj_sum;
	logic [apl_pkg::LevelW-1:0]         adj;
	logic signed [apl_pkg::MinW-1:0]    adj_s;
	logic signed [apl_pkg::MinW-1:0]    min_nxt;
	logic [apl_pkg::LevelW-1:0]         max_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q  <= apl_pkg::FMT_S16;
			be_q   <= 1'b0;
			gain_q <= '0;
			mult_q <= apl_pkg::MULT_UNITY;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				apl_pkg::REG_SAMPLE_FORMAT: fmt_q  <= cfg_data[2:0];
				apl_pkg::REG_BIG_ENDIAN:    be_q   <= cfg_data[0];
				apl_pkg::REG_LEVEL_GAIN:    gain_q <= cfg_data[apl_pkg::GainW-1:0];
				apl_pkg::REG_LEVEL_MULT:    mult_q <= cfg_data[apl_pkg::MultW-1:0];
			endcase
		end
	end

	// Sample decode. Signed formats take the two's complement magnitude; the most
	// negative code lands one above full scale and is clamped when the buffer ends.
	always_comb begin
		b0  = sample_word[7:0];
		b1  = sample_word[15:8];
		b2  = sample_word[23:16];
		b3  = sample_word[31:24];
		v16 = be_q ? {b0, b1} : {b1, b0};
		v32 = be_q ? {b0, b1, b2, b3} : sample_word;
		case (fmt_q)
			apl_pkg::FMT_U8:  mag = {24'd0, b0};
			apl_pkg::FMT_S8:  mag = {24'd0, (b0[7] ? 8'd0 - b0 : b0)};
			apl_pkg::FMT_U16: mag = {16'd0, v16};
			apl_pkg::FMT_S16: mag = {16'd0, (v16[15] ? 16'd0 - v16 : v16)};
			apl_pkg::FMT_S32: mag = v32[31] ? 32'd0 - v32 : v32;
			default:          mag = v32;
		endcase
		case (fmt_q)
			apl_pkg::FMT_U8:  fs = apl_pkg::FS_U8;
			apl_pkg::FMT_S8:  fs = apl_pkg::FS_S8;
			apl_pkg::FMT_U16: fs = apl_pkg::FS_U16;
			apl_pkg::FMT_S16: fs = apl_pkg::FS_S16;
			apl_pkg::FMT_U32: fs = apl_pkg::FS_U32;
			apl_pkg::FMT_S32: fs = apl_pkg::FS_S32;
			default:          fs = '0;
		endcase
		peak_max   = (mag > peak_acc_q) ? mag : peak_acc_q;
		peak_clamp = (peak_max > fs) ? fs : peak_max;
	end

	// One quotient bit per cycle, most significant first. The peak never exceeds
	// full scale, so the quotient fits in seven bits.
	always_comb begin
		div_sub = apl_pkg::NumW'(fs) << ctl.div_idx;
		div_ge  = (num_q >= div_sub);
	end

	always_comb begin
		adj_sum = $signed({2'b00, prod_q[apl_pkg::ProdW-1:8]})
			+ $signed({{5{gain_q[apl_pkg::GainW-1]}}, gain_q});
		if (adj_sum < 13'sd0) begin
			adj = '0;
		end else if (adj_sum > $signed({6'd0, apl_pkg::PERCENT})) begin
			adj = apl_pkg::PERCENT;
		end else begin
			adj = adj_sum[apl_pkg::LevelW-1:0];
		end
		adj_s   = $signed({1'b0, adj});
		min_nxt = (min_q == $signed(apl_pkg::MIN_NONE) || adj_s < min_q) ? adj_s : min_q;
		max_nxt = (adj > max_q) ? adj : max_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_acc_q  <= '0;
			min_q       <= $signed(apl_pkg::MIN_NONE);
			max_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctl.last_load) begin
				peak_acc_q <= '0;
			end else if (ctl.acc_en) begin
				peak_acc_q <= peak_max;
			end
			if (ctl.clear_tel) begin
				min_q <= $signed(apl_pkg::MIN_NONE);
				max_q <= '0;
			end else if (ctl.commit) begin
				min_q <= min_nxt;
				max_q <= max_nxt;
			end
			if (ctl.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.last_load) begin
			peak_w_q <= peak_clamp;
		end
		if (ctl.mul_en) begin
			num_q <= apl_pkg::NumW'(peak_w_q) * apl_pkg::NumW'(apl_pkg::PERCENT);
			quo_q <= '0;
		end else if (ctl.div_en) begin
			if (div_ge) begin
				num_q <= num_q - div_sub;
			end
			quo_q[ctl.div_idx] <= div_ge;
		end
		if (ctl.scale_en) begin
			prod_q <= apl_pkg::ProdW'(quo_q) * apl_pkg::ProdW'(mult_q);
		end
		if (ctl.commit) begin
			level_raw      <= quo_q;
			level_adjusted <= adj;
			level_min      <= min_nxt;
			level_max      <= max_nxt;
		end
	end

	assign stat.fs_valid = (fs != '0);
	assign stat.out_free = !out_valid_q || out_ready;
	assign out_valid     = out_valid_q;

endmodule

// File: dv/audio_peak_level_meter_top_tb.sv
// Self-checking testbench for the audio peak level meter top level.
// Drives the sample, result and configuration channels from apl_if and scores every result
// against a level predictor kept in a small scoreboard class; depends on apl_pkg.
module audio_peak_level_meter_top_tb;
	import apl_pkg::*;

	localparam int HOLD_CYCLES   = 300;
	localparam int SETTLE_CYCLES = 16;
	localparam int QUIET_LIMIT   = 4000;
	localparam int NUM_PHASES    = 12;
	localparam int PHASE_ITEMS   = 155;

	class level_scoreboard;
		typedef struct {
			logic [LevelW-1:0] raw;
			logic [LevelW-1:0] adj;
			logic [MinW-1:0]   lo;
			logic [LevelW-1:0] hi;
		} levels_t;

		levels_t                  level_q[$];
		logic [2:0]               fmt;
		logic                     be;
		logic signed [GainW-1:0]  gain;
		logic [MultW-1:0]         mult;
		logic [WordW-1:0]         peak;
		int                       min_lvl;
		int                       max_lvl;
		int                       errors;

		function new();
			fmt     = FMT_S16;
			be      = 1'b0;
			gain    = '0;
			mult    = MULT_UNITY;
			peak    = '0;
			min_lvl = -1;
			max_lvl = 0;
			errors  = 0;
		endfunction

		function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] d);
			case (idx)
			REG_SAMPLE_FORMAT: fmt = d[2:0];
			REG_BIG_ENDIAN:    be = d[0];
			REG_LEVEL_GAIN:    gain = d[GainW-1:0];
			REG_LEVEL_MULT:    mult = d[MultW-1:0];
			default: ;
			endcase
		endfunction

		function logic [WordW-1:0] magnitude(logic [WordW-1:0] w);
			logic [15:0] v16;
			logic [31:0] v32;
			v16 = be ? {w[7:0], w[15:8]} : w[15:0];
			v32 = be ? {w[7:0], w[15:8], w[23:16], w[31:24]} : w;
			case (fmt)
			FMT_U8:  return {24'd0, w[7:0]};
			FMT_S8:  return w[7] ? 32'h100 - {24'd0, w[7:0]} : {24'd0, w[7:0]};
			FMT_U16: return {16'd0, v16};
			FMT_S16: return v16[15] ? 32'h10000 - {16'd0, v16} : {16'd0, v16};
			FMT_S32: return v32[31] ? -v32 : v32;
			default: return v32;
			endcase
		endfunction

		function logic [WordW-1:0] full_scale();
			case (fmt)
			FMT_U8:  return FS_U8;
			FMT_S8:  return FS_S8;
			FMT_U16: return FS_U16;
			FMT_S16: return FS_S16;
			FMT_U32: return FS_U32;
			FMT_S32: return FS_S32;
			default: return '0;
			endcase
		endfunction

		// Called for every accepted input word; queues a result at each buffer end whose format has a full scale.
		function void note_word(logic c, logic [WordW-1:0] w, logic is_last);
			logic [WordW-1:0] fs;
			logic [WordW-1:0] pk;
			logic [WordW-1:0] m;
			longint unsigned  num;
			int unsigned      raw;
			int               scaled;
			int               g;
			int               adj;
			levels_t          e;
			if (c == CMD_CLEAR) begin
				min_lvl = -1;
				max_lvl = 0;
				return;
			end
			m = magnitude(w);
			if (m > peak)
				peak = m;
			if (!is_last)
				return;
			fs = full_scale();
			pk = peak;
			peak = '0;
			// Unused format codes have no full scale and end the buffer silently.
			if (fs == 0)
				return;
			if (pk > fs)
				pk = fs;
			num = pk;
			num = num * 100;
			raw = num / fs;
			scaled = (raw * mult) >> 8;
			g = gain;
			adj = scaled + g;
			if (adj > 100)
				adj = 100;
			if (adj < 0)
				adj = 0;
			if (min_lvl == -1 || adj < min_lvl)
				min_lvl = adj;
			if (adj > max_lvl)
				max_lvl = adj;
			e.raw = raw[LevelW-1:0];
			e.adj = adj[LevelW-1:0];
			e.lo  = min_lvl[MinW-1:0];
			e.hi  = max_lvl[LevelW-1:0];
			level_q.insert(level_q.size(), e);
		endfunction

		task report_mismatch(string msg);
			$display("MISMATCH @%0t: %s", $time, msg);
			errors++;
		endtask

		task check_levels(logic [LevelW-1:0] raw, logic [LevelW-1:0] adj,
				logic [MinW-1:0] lo, logic [LevelW-1:0] hi);
			levels_t e;
			if (level_q.size() == 0) begin
				report_mismatch($sformatf("unexpected result raw=%0d adj=%0d", raw, adj));
				return;
			end
			e = level_q.pop_front();
			if (raw !== e.raw)
				report_mismatch($sformatf("level_raw %0d, want %0d", raw, e.raw));
			if (adj !== e.adj)
				report_mismatch($sformatf("level_adjusted %0d, want %0d", adj, e.adj));
			if (lo !== e.lo)
				report_mismatch($sformatf("level_min %0d, want %0d",
					$signed(lo), $signed(e.lo)));
			if (hi !== e.hi)
				report_mismatch($sformatf("level_max %0d, want %0d", hi, e.hi));
		endtask

		task flush_leftover();
			while (level_q.size() != 0) begin
				report_mismatch("expected result never arrived");
				void'(level_q.pop_front());
			end
		endtask
	endclass

	logic clk;
	logic arst_n;
	bit   tx_idle;
	bit   rx_idle;
	bit   hold_req;
	int   quiet_cycles;

	level_scoreboard sb;

	apl_in_if  in_ch ();
	apl_out_if out_ch ();
	apl_cfg_if cfg ();

	audio_peak_level_meter_top u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.cfg    (cfg)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// All acceptances are scored from one block so their order is fixed.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg.valid && cfg.ready)
				sb.set_reg(cfg.index, cfg.data);
			if (in_ch.valid && in_ch.ready)
				sb.note_word(in_ch.cmd, in_ch.sample_word, in_ch.last_sample);
			if (out_ch.valid && out_ch.ready)
				sb.check_levels(out_ch.level_raw, out_ch.level_adjusted,
					out_ch.level_min, out_ch.level_max);
			if ((cfg.valid && cfg.ready) || (in_ch.valid && in_ch.ready) ||
					(out_ch.valid && out_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	// Result side: random stalls per word, plus one long hold when asked.
	initial begin
		int stall;
		out_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				out_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				stall = rx_idle ? $urandom_range(0, 15) : 0;
				if (stall != 0) begin
					out_ch.ready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
			end
			out_ch.ready <= 1'b1;
			@(posedge clk);
			while (!out_ch.valid && !hold_req) @(posedge clk);
		end
	end

	// Leaves valid high after the handshake so back-to-back words need no extra edge.
	task automatic send_word(input logic c, input logic [WordW-1:0] w, input logic is_last);
		int gap;
		gap = tx_idle ? $urandom_range(0, 15) : 0;
		if (gap != 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid       <= 1'b1;
		in_ch.cmd         <= c;
		in_ch.sample_word <= w;
		in_ch.last_sample <= is_last;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] d);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= d;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
	endtask

	// Unused data bits carry random values; the block must ignore them.
	task automatic apply_setting(input logic [2:0] f, input logic b,
			input logic [GainW-1:0] g, input logic [MultW-1:0] m);
		logic [31:0] junk;
		junk = $urandom;
		write_reg(REG_SAMPLE_FORMAT, {junk[11:3], f});
		junk = $urandom;
		write_reg(REG_BIG_ENDIAN, {junk[11:1], b});
		junk = $urandom;
		write_reg(REG_LEVEL_GAIN, {junk[11:8], g});
		write_reg(REG_LEVEL_MULT, m);
		cfg.valid <= 1'b0;
	endtask

	// Stop offering words, wait for every queued result, then let a silent buffer end finish.
	task automatic settle();
		in_ch.valid <= 1'b0;
		do @(posedge clk); while (sb.level_q.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [WordW-1:0] pick_word();
		case ($urandom_range(0, 9))
		0: return 32'h0;
		1: return 32'hffff_ffff;
		2: begin
			case ($urandom_range(0, 4))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'h0000_8000;
			3: return 32'h0000_0080;
			default: return 32'h0000_7fff;
			endcase
		end
		3: return 32'($urandom_range(0, 255)) << (8 * $urandom_range(0, 3));
		default: return $urandom;
		endcase
	endfunction

	// Mostly well-formed buffers of random length, with an occasional clear mixed in.
	task automatic run_buffers(input int n);
		int cnt;
		int len;
		cnt = 0;
		while (cnt < n) begin
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 5);
			for (int i = 0; i < len; i++) begin
				if ($urandom_range(0, 24) == 0) begin
					send_word(CMD_CLEAR, $urandom, 1'($urandom));
					cnt++;
				end
				send_word(CMD_SAMPLE, pick_word(), i == len - 1);
				cnt++;
			end
		end
	endtask

	initial begin
		logic [2:0]       f_sel;
		logic [GainW-1:0] g_sel;
		logic [MultW-1:0] m_sel;
		sb = new();
		arst_n            = 1'b0;
		in_ch.valid       = 1'b0;
		in_ch.cmd         = CMD_SAMPLE;
		in_ch.sample_word = '0;
		in_ch.last_sample = 1'b0;
		cfg.valid         = 1'b0;
		cfg.index         = REG_SAMPLE_FORMAT;
		cfg.data          = '0;
		tx_idle           = 1'b0;
		rx_idle           = 1'b0;
		hold_req          = 1'b0;
		quiet_cycles      = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: positive full scale, most negative sample, a clear that carries
		// a last flag, and a buffer whose peak rounds down to zero.
		send_word(CMD_SAMPLE, 32'h0000_7fff, 1'b1);
		send_word(CMD_SAMPLE, 32'h0000_8000, 1'b1);
		send_word(CMD_CLEAR, 32'hffff_ffff, 1'b1);
		send_word(CMD_SAMPLE, 32'hffff_0000, 1'b0);
		send_word(CMD_SAMPLE, 32'h0000_ffff, 1'b1);

		// Every format code, both byte orders along the way, including the unused codes.
		for (int f = 0; f < 8; f++) begin
			settle();
			apply_setting(f[2:0], f[0], 8'd0, MULT_UNITY);
			send_word(CMD_SAMPLE, 32'hffff_ffff, 1'b1);
			send_word(CMD_SAMPLE, 32'h8000_0080, 1'b1);
		end

		// Zero multiplier with the most negative gain, then the largest of both, then gain -99 with a multiplier of 1.
		settle();
		apply_setting(FMT_S16, 1'b0, 8'h80, 12'd0);
		send_word(CMD_SAMPLE, 32'h0000_7fff, 1'b1);
		settle();
		apply_setting(FMT_S16, 1'b0, 8'h7f, 12'hfff);
		send_word(CMD_SAMPLE, 32'h0000_4000, 1'b1);
		settle();
		apply_setting(FMT_U8, 1'b0, 8'h9d, 12'd1);
		send_word(CMD_SAMPLE, 32'h0000_00c8, 1'b1);

		for (int p = 0; p < NUM_PHASES; p++) begin
			settle();
			case (p)
			0: apply_setting(FMT_U8, 1'b0, 8'h80, 12'd0);
			1: apply_setting(FMT_S32, 1'b1, 8'h7f, 12'hfff);
			2: apply_setting(FMT_S16, 1'b1, 8'h9d, 12'd2560);
			3: apply_setting(FMT_U16, 1'b0, 8'd99, 12'd1);
			default: begin
				f_sel = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(6, 7))
					: 3'($urandom_range(0, 5));
				g_sel = $urandom_range(0, 1) ? 8'($urandom_range(0, 198) - 99) : 8'($urandom);
				m_sel = $urandom_range(0, 1) ? 12'($urandom_range(1, 2560)) : 12'($urandom);
				apply_setting(f_sel, 1'($urandom), g_sel, m_sel);
			end
			endcase
			case (p)
			0: begin
				tx_idle = 1'b0;
				rx_idle = 1'b0;
			end
			1: begin
				tx_idle = 1'b1;
				rx_idle = 1'b1;
			end
			2: begin
				// Sender runs flat out while the result side holds off, so the block
				// backs up and must stall its input.
				tx_idle  = 1'b0;
				rx_idle  = 1'b0;
				hold_req = 1'b1;
			end
			default: begin
				tx_idle = 1'($urandom);
				rx_idle = 1'($urandom);
			end
			endcase
			run_buffers(PHASE_ITEMS);
		end

		settle();
		sb.flush_leftover();
		if (sb.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
